@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the frame builder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RWFB_ASSERT(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) \
    else $error("assertion failed");
`define RWFB_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define RWFB_ASSERT(lbl, clk_s, rstn_s, prop)
`define RWFB_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)
`endif
`endif

@@ hw/rtl/rwfb_pkg.sv @@
// Types and constants of the register write frame builder.
`timescale 1ns / 1ps
`default_nettype none
package rwfb_pkg;

  localparam int MAX_FRAME_VALUES = 32;
  localparam int FRAME_CNT_W      = 7;
  localparam int JOB_FIFO_DEPTH   = 4;
  localparam int JOB_PTR_W        = $clog2(JOB_FIFO_DEPTH);
  localparam int JOB_CNT_W        = $clog2(JOB_FIFO_DEPTH + 1);

  localparam logic [7:0] SYNC_A    = 8'hEB;
  localparam logic [7:0] SYNC_B    = 8'h90;
  localparam logic [7:0] CMD_WRITE = 8'h12;

  localparam int          CFG_ADDR_W      = 2;
  localparam logic [1:0]  ADDR_DEVICE_ID  = 2'd0;

  typedef struct packed {
    logic        first_of_run;
    logic [15:0] start_address;
    logic [15:0] total_values;
    logic [15:0] reg_value;
  } rwfb_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       item_end;
  } rwfb_out_t;

  // One accepted value as the back end needs it
  typedef struct packed {
    logic        open;
    logic        close;
    logic [7:0]  dev_id;
    logic [7:0]  len;
    logic [15:0] addr;
    logic [15:0] value;
  } rwfb_job_t;

endpackage
`default_nettype wire

@@ hw/rtl/rwfb_job_fifo.sv @@
// Short job queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rwfb_job_fifo (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire rwfb_pkg::rwfb_job_t wr_data,
  output logic                    full,
  input  wire logic               pop,
  output rwfb_pkg::rwfb_job_t     rd_data,
  output logic                    empty
);

  rwfb_pkg::rwfb_job_t                   mem_r [rwfb_pkg::JOB_FIFO_DEPTH];
  logic [rwfb_pkg::JOB_PTR_W-1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [rwfb_pkg::JOB_PTR_W-1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [rwfb_pkg::JOB_CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                                  do_push, do_pop;

  assign full    = (cnt_r == rwfb_pkg::JOB_CNT_W'(rwfb_pkg::JOB_FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  `RWFB_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= rwfb_pkg::JOB_CNT_W'(rwfb_pkg::JOB_FIFO_DEPTH))
  `RWFB_ASSERT_IMP(a_no_push_full, clk, rst_n, push, !full)
  `RWFB_ASSERT(a_ptr_gap, clk, rst_n, (cnt_r == '0 || full) == (wr_ptr_r == rd_ptr_r))

endmodule
`default_nettype wire

@@ hw/rtl/rwfb_front.sv @@
// Front end: run bookkeeping, frame splitting and job issue.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rwfb_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire rwfb_pkg::rwfb_in_t  in_data,
  input  wire logic [7:0]          device_id,
  output logic                     job_push,
  output rwfb_pkg::rwfb_job_t      job
);

  localparam int FW = rwfb_pkg::FRAME_CNT_W;

  logic          run_active_r, run_active_nxt;
  logic [15:0]   values_left_r, values_left_nxt;
  logic [FW-1:0] frame_left_r, frame_left_nxt;
  logic [15:0]   frame_addr_r, frame_addr_nxt;

  logic          act;
  logic [15:0]   vr;
  logic [FW-1:0] fvl;
  logic [15:0]   adr;
  logic          open;
  logic [FW-1:0] n;
  logic [FW-1:0] fvl_dec;
  logic [15:0]   vr_dec;

  always_comb begin
    act      = run_active_r;
    vr       = values_left_r;
    fvl      = frame_left_r;
    adr      = frame_addr_r;
    open     = 1'b0;
    n        = '0;
    fvl_dec  = '0;
    vr_dec   = '0;
    job_push = 1'b0;
    job      = '0;
    run_active_nxt  = run_active_r;
    values_left_nxt = values_left_r;
    frame_left_nxt  = frame_left_r;
    frame_addr_nxt  = frame_addr_r;
    if (accept) begin
      // a new run abandons any open frame
      if (in_data.first_of_run) begin
        fvl = '0;
        if (in_data.total_values == '0) begin
          act = 1'b0;
          vr  = '0;
        end else begin
          act = 1'b1;
          vr  = in_data.total_values;
          adr = in_data.start_address;
        end
      end
      if (!act || vr == '0) begin
        run_active_nxt  = 1'b0;
        values_left_nxt = vr;
        frame_left_nxt  = fvl;
        frame_addr_nxt  = adr;
      end else begin
        open    = (fvl == '0);
        n       = (vr > 16'(rwfb_pkg::MAX_FRAME_VALUES)) ?
                  FW'(rwfb_pkg::MAX_FRAME_VALUES) : vr[FW-1:0];
        fvl_dec = (open ? n : fvl) - 1'b1;
        vr_dec  = vr - 16'd1;
        job_push   = 1'b1;
        job.open   = open;
        job.close  = (fvl_dec == '0);
        job.dev_id = device_id;
        job.len    = {n, 1'b0} + 8'd3;
        job.addr   = adr;
        job.value  = in_data.reg_value;
        values_left_nxt = vr_dec;
        frame_addr_nxt  = adr + 16'd1;
        if (vr_dec == '0) begin
          run_active_nxt = 1'b0;
          frame_left_nxt = '0;
        end else begin
          run_active_nxt = 1'b1;
          frame_left_nxt = fvl_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_active_r  <= 1'b0;
      values_left_r <= '0;
      frame_left_r  <= '0;
      frame_addr_r  <= '0;
    end else begin
      run_active_r  <= run_active_nxt;
      values_left_r <= values_left_nxt;
      frame_left_r  <= frame_left_nxt;
      frame_addr_r  <= frame_addr_nxt;
    end
  end

  `RWFB_ASSERT_IMP(a_idle_no_frame, clk, rst_n, !run_active_r, frame_left_r == '0)
  `RWFB_ASSERT_IMP(a_active_has_values, clk, rst_n, run_active_r, values_left_r != '0)
  `RWFB_ASSERT_IMP(a_push_needs_accept, clk, rst_n, job_push, accept)

endmodule
`default_nettype wire

@@ hw/rtl/rwfb_back.sv @@
// Back end: byte sequencer, checksum and output buffer.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rwfb_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                job_valid,
  input  wire rwfb_pkg::rwfb_job_t job,
  output logic                     job_pop,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output rwfb_pkg::rwfb_out_t      out_data
);

  typedef enum logic [3:0] {
    SLOT_SYNC_A  = 4'd0,
    SLOT_SYNC_B  = 4'd1,
    SLOT_DEV     = 4'd2,
    SLOT_LEN     = 4'd3,
    SLOT_CMD     = 4'd4,
    SLOT_ADDR_LO = 4'd5,
    SLOT_ADDR_HI = 4'd6,
    SLOT_VAL_LO  = 4'd7,
    SLOT_VAL_HI  = 4'd8,
    SLOT_SUM     = 4'd9
  } slot_t;

  logic                 in_job_r, in_job_nxt;
  slot_t                slot_r, slot_nxt;
  logic [7:0]           sum_r, sum_nxt;
  rwfb_pkg::rwfb_out_t  ob_r [2];
  logic                 ob_wr_r, ob_rd_r;
  logic [1:0]           ob_cnt_r, ob_cnt_nxt;

  slot_t                cur_slot, last_slot;
  logic                 emit, ob_pop;
  logic [7:0]           cur_byte;
  rwfb_pkg::rwfb_out_t  beat;

  assign cur_slot  = in_job_r ? slot_r : (job.open ? SLOT_SYNC_A : SLOT_VAL_LO);
  assign last_slot = job.close ? SLOT_SUM : SLOT_VAL_HI;
  assign emit      = job_valid && (ob_cnt_r != 2'd2);
  assign job_pop   = emit && (cur_slot == last_slot);
  assign ob_pop    = out_pop && (ob_cnt_r != 2'd0);
  assign out_empty = (ob_cnt_r == 2'd0);
  assign out_data  = ob_r[ob_rd_r];

  always_comb begin
    case (cur_slot)
      SLOT_SYNC_A:  cur_byte = rwfb_pkg::SYNC_A;
      SLOT_SYNC_B:  cur_byte = rwfb_pkg::SYNC_B;
      SLOT_DEV:     cur_byte = job.dev_id;
      SLOT_LEN:     cur_byte = job.len;
      SLOT_CMD:     cur_byte = rwfb_pkg::CMD_WRITE;
      SLOT_ADDR_LO: cur_byte = job.addr[7:0];
      SLOT_ADDR_HI: cur_byte = job.addr[15:8];
      SLOT_VAL_LO:  cur_byte = job.value[7:0];
      SLOT_VAL_HI:  cur_byte = job.value[15:8];
      SLOT_SUM:     cur_byte = sum_r;
      default:      cur_byte = '0;
    endcase
    beat.out_byte  = cur_byte;
    beat.frame_end = (cur_slot == SLOT_SUM);
    beat.item_end  = job_pop;
  end

  always_comb begin
    in_job_nxt = in_job_r;
    slot_nxt   = slot_r;
    sum_nxt    = sum_r;
    if (emit) begin
      in_job_nxt = !job_pop;
      slot_nxt   = slot_t'(4'(cur_slot) + 4'd1);
      // checksum covers the id byte through the last value byte
      case (cur_slot)
        SLOT_DEV:     sum_nxt = cur_byte;
        SLOT_LEN,
        SLOT_CMD,
        SLOT_ADDR_LO,
        SLOT_ADDR_HI,
        SLOT_VAL_LO,
        SLOT_VAL_HI:  sum_nxt = sum_r + cur_byte;
        default:      sum_nxt = sum_r;
      endcase
    end
    ob_cnt_nxt = ob_cnt_r;
    if (emit && !ob_pop) begin
      ob_cnt_nxt = ob_cnt_r + 2'd1;
    end else if (ob_pop && !emit) begin
      ob_cnt_nxt = ob_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_job_r <= 1'b0;
      slot_r   <= SLOT_SYNC_A;
      sum_r    <= '0;
      ob_wr_r  <= 1'b0;
      ob_rd_r  <= 1'b0;
      ob_cnt_r <= '0;
    end else begin
      in_job_r <= in_job_nxt;
      slot_r   <= slot_nxt;
      sum_r    <= sum_nxt;
      ob_cnt_r <= ob_cnt_nxt;
      if (emit) begin
        ob_wr_r <= !ob_wr_r;
      end
      if (ob_pop) begin
        ob_rd_r <= !ob_rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ob_r[ob_wr_r] <= beat;
    end
  end

  `RWFB_ASSERT(a_ob_bound, clk, rst_n, ob_cnt_r <= 2'd2)
  `RWFB_ASSERT_IMP(a_mid_job_valid, clk, rst_n, in_job_r, job_valid)
  `RWFB_ASSERT_IMP(a_mid_job_slot, clk, rst_n, in_job_r,
                   slot_r != SLOT_SYNC_A && 4'(slot_r) <= 4'(SLOT_SUM))
  `RWFB_ASSERT_IMP(a_frame_end_last, clk, rst_n, emit && cur_slot == SLOT_SUM, job_pop)

endmodule
`default_nettype wire

@@ hw/rtl/register_write_frame_builder.sv @@
// Frame builder top level: config register, front end, job queue, back end.
// The first byte of an item's frame passes through the registered job queue and then the output buffer.
// Throughput: one output byte per cycle from the back end's sequencer while a job is queued
// and the output buffer has room. Items are 2 bytes, 9 opening a frame, plus 1 closing one.
// A 4-deep job queue lets the front end keep accepting while the back end drains bytes.
// Reset (synchronous, rst_n low) clears device_id, run state, both queues and the checksum.
`timescale 1ns / 1ps
`default_nettype none
module register_write_frame_builder (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_push,
  output logic                                    in_full,
  input  wire rwfb_pkg::rwfb_in_t                 in_data,
  output logic                                    out_empty,
  input  wire logic                               out_pop,
  output rwfb_pkg::rwfb_out_t                     out_data,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [rwfb_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [31:0]                        cfg_pwdata,
  output logic [31:0]                             cfg_prdata,
  output logic                                    cfg_pready
);

  logic [7:0]          device_id_r, device_id_nxt;
  logic                cfg_wr;
  logic                accept;
  logic                job_push, job_pop, job_full, job_empty;
  rwfb_pkg::rwfb_job_t job_in, job_head;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == rwfb_pkg::ADDR_DEVICE_ID) ? {24'd0, device_id_r} : 32'd0;

  always_comb begin
    device_id_nxt = device_id_r;
    if (cfg_wr && cfg_paddr == rwfb_pkg::ADDR_DEVICE_ID) begin
      device_id_nxt = cfg_pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_id_r <= '0;
    end else begin
      device_id_r <= device_id_nxt;
    end
  end

  assign in_full = job_full;
  assign accept  = in_push && !job_full;

  rwfb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .device_id (device_id_r),
    .job_push  (job_push),
    .job       (job_in)
  );

  rwfb_job_fifo u_job_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .wr_data (job_in),
    .full    (job_full),
    .pop     (job_pop),
    .rd_data (job_head),
    .empty   (job_empty)
  );

  rwfb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!job_empty),
    .job       (job_head),
    .job_pop   (job_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
